// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define B64D_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("b64d assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define B64D_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("b64d assertion failed");

`endif

// ===== rtl/core/b64d_pkg.sv =====
// Shared type and character constants of the base64 stream decoder.
package b64d_pkg;

  localparam logic [7:0] CharUpA  = 8'h41;
  localparam logic [7:0] CharUpZ  = 8'h5A;
  localparam logic [7:0] CharLoA  = 8'h61;
  localparam logic [7:0] CharLoZ  = 8'h7A;
  localparam logic [7:0] CharDig0 = 8'h30;
  localparam logic [7:0] CharDig9 = 8'h39;
  localparam logic [7:0] CharPlus = 8'h2B;
  localparam logic [7:0] CharSlash = 8'h2F;
  localparam logic [7:0] CharPad  = 8'h3D;

  // One group of results caused by a single item.
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  cnt;
    logic        is_status;
    logic        status;
  } grp_t;

endpackage

// ===== rtl/core/b64d_decode.sv =====
// Input register, decoder state and quartet decode of the base64 stream decoder.
module b64d_decode import b64d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       op_i,
  input  logic [7:0] char_in_i,
  input  logic       grp_ready_i,
  output logic       grp_push_o,
  output grp_t       grp_o
);

  typedef enum logic [2:0] {
    PhCollect = 3'b001,
    PhError   = 3'b010,
    PhDone    = 3'b100
  } phase_e;

  // Returns {is_sextet, value}.
  function automatic logic [6:0] map_char(input logic [7:0] c);
    logic [6:0] r;
    r = 7'd0;
    if (c inside {[CharUpA:CharUpZ]}) begin
      r = {1'b1, 6'(c - CharUpA)};
    end else if (c inside {[CharLoA:CharLoZ]}) begin
      r = {1'b1, 6'(c - CharLoA + 8'd26)};
    end else if (c inside {[CharDig0:CharDig9]}) begin
      r = {1'b1, 6'(c - CharDig0 + 8'd52)};
    end else if (c == CharPlus) begin
      r = {1'b1, 6'd62};
    end else if (c == CharSlash) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

  logic       itm_vld_q;
  logic       itm_op_q;
  logic [7:0] itm_char_q;

  phase_e     phase_q, phase_d;
  logic [1:0] fill_q, fill_d;
  logic [1:0] pad_q, pad_d;
  logic [5:0] held_q [3];

  logic [6:0] sx;
  logic       is_pad;
  logic [5:0] sym;
  logic [2:0] pads;
  logic       held_we;
  logic       has_res;
  logic       advance;
  grp_t       grp;

  always_comb begin
    sx      = map_char(itm_char_q);
    is_pad  = (itm_char_q == CharPad);
    sym     = is_pad ? 6'd0 : sx[5:0];
    pads    = {1'b0, pad_q} + {2'b00, is_pad};
    phase_d = phase_q;
    fill_d  = fill_q;
    pad_d   = pad_q;
    held_we = 1'b0;
    has_res = 1'b0;
    grp     = '0;
    if (itm_op_q) begin
      // End of stream: report and rearm.
      has_res       = 1'b1;
      grp.cnt       = 2'd1;
      grp.is_status = 1'b1;
      grp.status    = (phase_q == PhError) || ((phase_q == PhCollect) && (fill_q != 2'd0));
      phase_d       = PhCollect;
      fill_d        = 2'd0;
      pad_d         = 2'd0;
    end else if ((phase_q == PhCollect) && (is_pad || sx[6])) begin
      if (!is_pad && (pad_q != 2'd0)) begin
        phase_d = PhError;
      end else if (fill_q != 2'd3) begin
        held_we = 1'b1;
        fill_d  = fill_q + 2'd1;
        pad_d   = pads[1:0];
      end else if (pads > 3'd2) begin
        phase_d = PhError;
      end else begin
        has_res  = 1'b1;
        grp.word = {held_q[0], held_q[1], held_q[2], sym};
        grp.cnt  = 2'(3'd3 - pads);
        fill_d   = 2'd0;
        pad_d    = 2'd0;
        if (pads != 3'd0) begin
          phase_d = PhDone;
        end
      end
    end
  end

  // Items without results never wait on the output side.
  assign advance    = itm_vld_q && (!has_res || grp_ready_i);
  assign in_ready_o = !itm_vld_q || advance;
  assign grp_push_o = advance && has_res;
  assign grp_o      = grp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      itm_vld_q <= 1'b0;
      phase_q   <= PhCollect;
      fill_q    <= 2'd0;
      pad_q     <= 2'd0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        itm_vld_q <= 1'b1;
      end else if (advance) begin
        itm_vld_q <= 1'b0;
      end
      if (advance) begin
        phase_q <= phase_d;
        fill_q  <= fill_d;
        pad_q   <= pad_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      itm_op_q   <= op_i;
      itm_char_q <= char_in_i;
    end
    if (advance && held_we) begin
      held_q[fill_q] <= sym;
    end
  end

endmodule

// ===== rtl/core/b64d_emit.sv =====
// Result register that hands out a group of up to three results one per cycle while out_ready_i is high.
module b64d_emit import b64d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       grp_push_i,
  input  grp_t       grp_i,
  output logic       grp_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       is_status_o,
  output logic       status_o,
  output logic       last_o
);

  logic       grp_vld_q;
  grp_t       grp_q;
  logic [1:0] idx_q;
  logic       is_last;

  assign is_last     = (idx_q == 2'(grp_q.cnt - 2'd1));
  assign grp_ready_o = !grp_vld_q || (out_ready_i && is_last);

  assign out_valid_o = grp_vld_q;
  assign is_status_o = grp_q.is_status;
  assign status_o    = grp_q.status;
  assign last_o      = is_last;

  always_comb begin
    case (idx_q)
      2'd0:    out_byte_o = grp_q.word[23:16];
      2'd1:    out_byte_o = grp_q.word[15:8];
      default: out_byte_o = grp_q.word[7:0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_vld_q <= 1'b0;
      idx_q     <= 2'd0;
    end else if (grp_push_i) begin
      grp_vld_q <= 1'b1;
      idx_q     <= 2'd0;
    end else if (grp_vld_q && out_ready_i) begin
      // Advance through the group, drop it after its last result.
      if (is_last) begin
        grp_vld_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (grp_push_i) begin
      grp_q <= grp_i;
    end
  end

endmodule

// ===== rtl/core/base64_stream_decoder.sv =====
// Base64 stream decoder: characters in, decoded bytes and stream status out.
//
// Input channel (in_valid_i/in_ready_o): one item per handshake, either a
// character (op_i = 0, char_in_i) or an end-of-stream mark (op_i = 1).
// Output channel (out_valid_o/out_ready_i): one result per handshake, a data
// byte (is_status_o = 0) or a stream status (is_status_o = 1, status_o = 1 on
// malformed input); last_o marks the last result of an input item.
// An item is taken into an input register and decoded there against the
// quartet state; its results land in the result register, which drives
// out_valid_o, once that register is free (grp_ready).
// Throughput: one input item per cycle while the result register can take
// its results; a completed quartet occupies the result register until each
// of its bytes (up to three) is taken. Skipped characters pass without waiting.
// A stalled receiver holds the result register; once an item with results
// reaches the input register, in_ready_o drops until results drain.
// Reset clears the decoder state to collecting with an empty quartet and
// empties both registers; no clearing pass is needed.
module base64_stream_decoder import b64d_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       op_i,
  input  logic [7:0] char_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       is_status_o,
  output logic       status_o,
  output logic       last_o
);

  logic grp_push;
  logic grp_ready;
  grp_t grp;

  b64d_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .char_in_i   (char_in_i),
    .grp_ready_i (grp_ready),
    .grp_push_o  (grp_push),
    .grp_o       (grp)
  );

  b64d_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_push_i  (grp_push),
    .grp_i       (grp),
    .grp_ready_o (grp_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .is_status_o (is_status_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule

// ===== rtl/core/b64d_checker.sv =====
// Port-level checks of the base64 stream decoder, bound to the top level.
`include "assert_macros.svh"

module b64d_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       is_status_o,
  input logic       status_o,
  input logic       last_o
);

  `B64D_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `B64D_ASSERT_IMP(a_status_last, out_valid_o && is_status_o, last_o)
  `B64D_ASSERT_IMP(a_data_ok, out_valid_o && !is_status_o, !status_o)
  `B64D_ASSERT_IMP(a_status_zero, out_valid_o && is_status_o, out_byte_o == 8'd0)

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (.*);
